// ===== src/assert_macros.svh =====
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Clocked implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/dvet_pkg.sv =====
// ----------------------------------------------------------------------------
// dvet_pkg
// Shared types, constants and the escape classifier for the DN value
// escape and trim block.
// ----------------------------------------------------------------------------
package dvet_pkg;

    localparam int BYTE_W             = 8;
    localparam int PEND_W             = 6;
    localparam int MAX_PENDING_SPACES = 62;
    localparam int FIFO_DEPTH         = 2;

    localparam logic [BYTE_W-1:0] CH_END    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ESCAPE = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;

    // One emit job: held spaces, optional backslash, then the character
    typedef struct packed {
        logic [PEND_W-1:0] spaces;
        logic              esc;
        logic [BYTE_W-1:0] ch;
    } cmd_t;

    function automatic logic needs_escape(input logic [BYTE_W-1:0] ch);
        logic r;
        r = (ch == CH_COMMA) || (ch == CH_EQUAL) || (ch == CH_NL) ||
            (ch == CH_PLUS)  || (ch == CH_LT)    || (ch == CH_GT) ||
            (ch == CH_HASH)  || (ch == CH_ESCAPE);
        return r;
    endfunction

endpackage

// ===== src/dn_value_escape_trim.sv =====
// ----------------------------------------------------------------------------
// dn_value_escape_trim
// Escapes and trims the spaces of one distinguished-name attribute value.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_byte) takes one character per item;
// a zero byte ends the value. Output channel (out_valid / out_stall /
// out_byte / run_last) gives the emitted bytes; run_last marks the last byte
// caused by one input item. Leading and trailing spaces are dropped, a held
// interior run (saturating at MAX_PENDING_SPACES) goes out before the next
// character, and special characters get a backslash first.
// The job queue, the current-job register and the output register lie in
// the path. A character emits its held spaces, then a backslash if special,
// then itself; spaces and end bytes produce nothing and are taken at 1 per
// cycle while the queue is not full. in_stall rises only when the 2-entry
// job queue between front and back is full. Reset clears the space state,
// the queue and out_valid. While out_stall is high the output byte holds and
// the front keeps taking items until the queue fills.
// ----------------------------------------------------------------------------
module dn_value_escape_trim #(
    parameter int MAX_PENDING_SPACES = dvet_pkg::MAX_PENDING_SPACES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dvet_pkg::BYTE_W-1:0] in_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dvet_pkg::BYTE_W-1:0] out_byte,
    output logic                        run_last
);
    import dvet_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    dvet_front #(
        .MAX_PENDING_SPACES(MAX_PENDING_SPACES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    dvet_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    dvet_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

// ===== src/dvet_front.sv =====
// ----------------------------------------------------------------------------
// dvet_front
// Accepts input bytes, tracks the leading/held space state and pushes one
// emit job per character other than space and end byte into the job queue.
// ----------------------------------------------------------------------------
module dvet_front #(
    parameter int MAX_PENDING_SPACES = dvet_pkg::MAX_PENDING_SPACES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dvet_pkg::BYTE_W-1:0] in_byte,
    input  logic                        q_full,
    output logic                        q_push,
    output dvet_pkg::cmd_t              q_cmd
);
    import dvet_pkg::*;

    typedef enum logic [2:0] {
        MODE_START = 3'b001,
        MODE_AFTER = 3'b010,
        MODE_RUN   = 3'b100
    } mode_t;

    localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(MAX_PENDING_SPACES);

    mode_t             mode_reg, mode_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Job for a character other than a space or end byte
    always_comb
    begin
        q_cmd.spaces = (mode_reg == MODE_RUN) ? pend_reg : '0;
        q_cmd.esc    = needs_escape(in_byte);
        q_cmd.ch     = in_byte;
        q_push       = accept && (in_byte != CH_END) && (in_byte != CH_SPACE);
    end

    // Space tracking
    always_comb
    begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        if (accept)
        begin
            if (in_byte == CH_END)
            begin
                mode_next = MODE_START;
                pend_next = '0;
            end
            else if (in_byte == CH_SPACE)
            begin
                unique case (mode_reg)
                    MODE_START: mode_next = MODE_START;
                    MODE_AFTER:
                    begin
                        mode_next = MODE_RUN;
                        pend_next = PEND_W'(1);
                    end
                    MODE_RUN:
                    begin
                        if (pend_reg < PEND_MAX)
                            pend_next = pend_reg + PEND_W'(1);
                    end
                    default: mode_next = MODE_START;
                endcase
            end
            else
            begin
                mode_next = MODE_AFTER;
                pend_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_START;
            pend_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== src/dvet_fifo.sv =====
// ----------------------------------------------------------------------------
// dvet_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module dvet_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dvet_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output dvet_pkg::cmd_t head_cmd
);
    import dvet_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== src/dvet_back.sv =====
// ----------------------------------------------------------------------------
// dvet_back
// Takes emit jobs from the queue and sends their bytes out one per cycle
// through a registered output stage while out_stall does not hold it.
// ----------------------------------------------------------------------------
module dvet_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  dvet_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dvet_pkg::BYTE_W-1:0] out_byte,
    output logic                        run_last
);
    import dvet_pkg::*;

    logic              cur_valid_reg, cur_valid_next;
    cmd_t              cur_reg, cur_next;
    logic              ov_reg, ov_next;
    logic [BYTE_W-1:0] ob_reg, ob_next;
    logic              ol_reg, ol_next;
    logic              advance, final_step;

    assign advance    = !ov_reg || !out_stall;
    assign final_step = (cur_reg.spaces == '0) && !cur_reg.esc;
    assign q_pop      = q_valid && (!cur_valid_reg || (advance && final_step));

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign run_last  = ol_reg;

    // Emit sequencer: spaces, then backslash, then the character
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        ov_next        = ov_reg;
        ob_next        = ob_reg;
        ol_next        = ol_reg;
        if (advance)
        begin
            ov_next = cur_valid_reg;
            if (cur_valid_reg)
            begin
                priority if (cur_reg.spaces != '0)
                begin
                    ob_next         = CH_SPACE;
                    ol_next         = 1'b0;
                    cur_next.spaces = cur_reg.spaces - PEND_W'(1);
                end
                else if (cur_reg.esc)
                begin
                    ob_next      = CH_ESCAPE;
                    ol_next      = 1'b0;
                    cur_next.esc = 1'b0;
                end
                else
                begin
                    ob_next        = cur_reg.ch;
                    ol_next        = 1'b1;
                    cur_valid_next = 1'b0;
                end
            end
        end
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = q_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            ov_reg        <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ob_reg  <= ob_next;
        ol_reg  <= ol_next;
    end

endmodule

// ===== src/dvet_checker.sv =====
// ----------------------------------------------------------------------------
// dvet_checker
// Port-level checks on the DN value escape and trim block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dvet_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [dvet_pkg::BYTE_W-1:0] out_byte,
    input logic                        run_last
);
    import dvet_pkg::*;

    logic out_acc;
    assign out_acc = out_valid && !out_stall;

    // Stalled output item holds
    `ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(out_byte) && $stable(run_last))

    // Bytes before the last of a run are spaces or the backslash
    `ASSERT_CLKD(a_prefix_byte, clk, rst_n,
                 !(out_valid && !run_last) || (out_byte == CH_SPACE) || (out_byte == CH_ESCAPE))

    // The last byte of a run is the character itself, never a space or end byte
    `ASSERT_CLKD(a_last_byte, clk, rst_n,
                 !(out_valid && run_last) || ((out_byte != CH_SPACE) && (out_byte != CH_END)))

    // A run does not pause once its first byte is taken
    `ASSERT_IMPL(a_run_continues, clk, rst_n, out_acc && !run_last, out_valid)

endmodule

bind dn_value_escape_trim dvet_checker u_dvet_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last)
);

// ===== bench/dn_value_escape_trim_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dn_value_escape_trim_tb
// Self-checking bench for the DN value escape and trim block. A queue of
// value characters feeds a clocked driver with random gaps. A clocked monitor
// applies random output stall and compares every emitted byte with a local
// model of the trimming and escaping rules.
// ----------------------------------------------------------------------------
module dn_value_escape_trim_tb;

    import dvet_pkg::*;

    localparam int LIMIT      = 1_000_000;
    localparam int TAIL_WAIT  = 20;
    localparam int TARGET     = 330;

    typedef enum logic [1:0] {
        SCAN_START,
        SCAN_TEXT,
        SCAN_SPACES
    } scan_t;

    // One character on its way to the block
    typedef struct {
        logic [BYTE_W-1:0] ch;
        int unsigned       gap;
        bit                drain;
    } value_char_t;

    // One byte the block should emit
    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              tail;
    } escaped_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] in_byte   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;

    value_char_t       value_chars[$];
    escaped_t          escaped_q[$];

    scan_t             scan_state   = SCAN_START;
    logic [PEND_W-1:0] held_spaces  = '0;
    int unsigned       gap_count    = 0;
    int unsigned       stall_left   = 0;
    int unsigned       rx_seen      = 0;
    bit                rx_calm      = 1'b0;
    int unsigned       err_count    = 0;
    int unsigned       cycle_count  = 0;

    logic [BYTE_W-1:0] specials[8] = '{CH_COMMA, CH_EQUAL, CH_NL, CH_PLUS,
                                       CH_LT, CH_GT, CH_HASH, CH_ESCAPE};

    dn_value_escape_trim DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic bit is_special_char(input logic [BYTE_W-1:0] ch);
        case (ch)
            CH_COMMA, CH_EQUAL, CH_NL, CH_PLUS,
            CH_LT, CH_GT, CH_HASH, CH_ESCAPE: return 1'b1;
            default:                          return 1'b0;
        endcase
    endfunction

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic add_char(input logic [BYTE_W-1:0] ch, input int unsigned gap,
                            input bit drain);
        value_char_t item;
        item.ch    = ch;
        item.gap   = gap;
        item.drain = drain;
        value_chars.push_back(item);
    endtask

    // Trim and escape model: queues the bytes one accepted character causes
    task automatic predict_escape(input logic [BYTE_W-1:0] ch);
        int n;
        if (ch == CH_END)
        begin
            scan_state  = SCAN_START;
            held_spaces = '0;
        end
        else if (ch == CH_SPACE)
        begin
            case (scan_state)
                SCAN_TEXT:
                begin
                    held_spaces = PEND_W'(1);
                    scan_state  = SCAN_SPACES;
                end
                SCAN_SPACES:
                begin
                    if (held_spaces < MAX_PENDING_SPACES)
                        held_spaces = held_spaces + PEND_W'(1);
                end
                default: scan_state = SCAN_START;
            endcase
        end
        else
        begin
            if (scan_state == SCAN_SPACES)
                for (n = 0; n < held_spaces; n++)
                    escaped_q.push_back('{CH_SPACE, 1'b0});
            if (is_special_char(ch))
                escaped_q.push_back('{CH_ESCAPE, 1'b0});
            escaped_q.push_back('{ch, 1'b1});
            held_spaces = '0;
            scan_state  = SCAN_TEXT;
        end
    endtask

    // Driver: presents queued characters, honors gaps and drain holds
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_escape(in_byte);
            if (!in_valid || !in_stall)
            begin
                if (value_chars.size() == 0)
                    in_valid <= 1'b0;
                else if (gap_count < value_chars[0].gap)
                begin
                    gap_count++;
                    in_valid <= 1'b0;
                end
                else if (value_chars[0].drain && escaped_q.size() != 0)
                    in_valid <= 1'b0;
                else
                begin
                    in_valid <= 1'b1;
                    in_byte  <= value_chars[0].ch;
                    void'(value_chars.pop_front());
                    gap_count = 0;
                end
            end
        end
    end

    // Monitor: random stall, compare each emitted item with the oldest one due
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (escaped_q.size() == 0)
                    report($sformatf("unexpected byte %02h", out_byte));
                else
                begin
                    if (out_byte !== escaped_q[0].ch)
                        report($sformatf("out_byte %02h, want %02h",
                                         out_byte, escaped_q[0].ch));
                    if (run_last !== escaped_q[0].tail)
                        report($sformatf("run_last %b, want %b on byte %02h",
                                         run_last, escaped_q[0].tail, escaped_q[0].ch));
                    void'(escaped_q.pop_front());
                end
                rx_seen++;
                // switch between calm and busy stretches now and then
                if (rx_seen % 48 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                stall_left = rx_calm ? 0 : $urandom_range(0, 6);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("dn_value_escape_trim verification failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned       counted;
        int unsigned       len;
        int unsigned       k;
        int unsigned       r;
        int unsigned       run;
        bit                calm;
        logic [BYTE_W-1:0] ch;

        // directed: leading spaces, every special, byte extremes
        add_char(CH_SPACE, 0, 0);
        add_char(CH_SPACE, 0, 0);
        add_char("A", 0, 0);
        foreach (specials[i])
            add_char(specials[i], 0, 0);
        add_char(8'h01, 0, 0);
        add_char(8'hFF, 0, 0);
        add_char(8'h7F, 0, 0);
        add_char(8'h80, 0, 0);
        // interior run is emitted before the next character
        add_char(CH_SPACE, 0, 0);
        add_char(CH_SPACE, 0, 0);
        add_char("c", 0, 0);
        // trailing spaces dropped by the end byte
        add_char(CH_SPACE, 0, 0);
        add_char(CH_SPACE, 0, 0);
        add_char(CH_END, 0, 0);
        // after the end byte a space is leading again
        add_char(CH_SPACE, 0, 0);
        add_char(CH_HASH, 0, 0);
        add_char(CH_END, 0, 0);

        // saturated space run, held after a full drain
        add_char("x", 0, 1);
        for (k = 0; k < 66; k++)
            add_char(CH_SPACE, 0, 0);
        add_char(CH_PLUS, 0, 0);
        add_char(CH_END, 0, 0);

        // random values: mostly well formed, a little noise
        counted = unsigned'(value_chars.size());
        while (counted < TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            len  = $urandom_range(0, 12);
            for (k = 0; k < len; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    ch = CH_SPACE;
                else if (r < 45)
                    ch = specials[$urandom_range(0, 7)];
                else if (r < 97)
                    ch = BYTE_W'($urandom_range(1, 255));
                else
                    ch = CH_END;
                add_char(ch, calm ? 0 : $urandom_range(0, 6),
                         $urandom_range(0, 39) == 0);
                counted++;
            end
            // occasional long run around the saturation point
            if ($urandom_range(0, 11) == 0)
            begin
                add_char("q", 0, 0);
                run = $urandom_range(58, 68);
                for (k = 0; k < run; k++)
                    add_char(CH_SPACE, calm ? 0 : $urandom_range(0, 1), 0);
                add_char(specials[$urandom_range(0, 7)], 0, 0);
                counted += run + 2;
            end
            add_char(CH_END, calm ? 0 : $urandom_range(0, 6), 0);
            counted++;
        end

        // wait for the driver to empty, then for the block to drain
        do
            @(negedge clk);
        while (value_chars.size() != 0 || in_valid);
        while (escaped_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);

        if (err_count == 0)
            $display("dn_value_escape_trim verification clean");
        else
            $display("dn_value_escape_trim verification failed");
        $finish;
    end

endmodule
